/* design/fpdiv_pkg.sv */
// ----------------------------------------------------------------------------
// fpdiv_pkg
// Shared types and constants for the binary32 divider pipeline.
// ----------------------------------------------------------------------------
package fpdiv_pkg;

	localparam logic [31:0] QNAN_DEFAULT = 32'h7fc00000;
	localparam logic [31:0] INF_BITS     = 32'h7f800000;
	localparam logic [22:0] QUIET_BIT    = 23'h400000;
	localparam logic [7:0]  EXP_ALL_ONES = 8'hff;
	localparam int          EXP_BIAS     = 127;
	localparam int          QUO_BITS     = 27;

	// Iteration state carried down the divider stages
	typedef struct packed {
		logic        special;
		logic [31:0] spec_val;
		logic        sign;
		logic [9:0]  exp;
		logic [24:0] rem;
		logic [23:0] dvsr;
		logic [26:0] quo;
	} div_state_t;

endpackage

/* design/fp32_divider_core.sv */
// ----------------------------------------------------------------------------
// fp32_divider_core
// IEEE-754 binary32 divider, round to nearest even, subnormals flushed.
// ----------------------------------------------------------------------------
// Fully pipelined: one request is taken every cycle (busy is held low) and
// its quotient leaves with done high after passing through the stages
// (one unpack stage, 27 restoring-division stages of one quotient bit each,
// one round stage). The output cannot be stalled, so the pipe never stops.
module fp32_divider_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] dividend_bits,
	input  logic [31:0] divisor_bits,
	output logic        done,
	output logic [31:0] quotient_bits
);
	import fpdiv_pkg::*;

	localparam int NSTG = QUO_BITS;

	// Unpack stage signals
	logic [7:0]  ea, eb;
	logic [22:0] fa, fb;
	logic        sgn;
	div_state_t  unp;

	always_comb begin
		ea  = dividend_bits[30:23];
		eb  = divisor_bits[30:23];
		fa  = dividend_bits[22:0];
		fb  = divisor_bits[22:0];
		sgn = dividend_bits[31] ^ divisor_bits[31];
		unp = '0;
		unp.sign = sgn;
		unp.exp  = 10'(({2'b0, ea} - {2'b0, eb}) + 10'(EXP_BIAS));
		unp.rem  = {1'b0, 1'b1, fa};
		unp.dvsr = {1'b1, fb};
		unp.special = 1'b1;
		if (ea == EXP_ALL_ONES) begin
			if (fa != '0)
				unp.spec_val = dividend_bits | {9'b0, QUIET_BIT};
			else if (eb == EXP_ALL_ONES)
				unp.spec_val = QNAN_DEFAULT;
			else
				unp.spec_val = {sgn, 31'b0} | INF_BITS;
		end else if (eb == EXP_ALL_ONES) begin
			if (fb != '0)
				unp.spec_val = divisor_bits | {9'b0, QUIET_BIT};
			else
				unp.spec_val = {sgn, 31'b0};
		end else if (divisor_bits[30:0] == '0) begin
			unp.spec_val = (dividend_bits[30:0] == '0) ? QNAN_DEFAULT
				: ({sgn, 31'b0} | INF_BITS);
		end else if (ea == '0) begin
			unp.spec_val = {sgn, 31'b0};
		end else if (eb == '0) begin
			unp.spec_val = {sgn, 31'b0} | INF_BITS;
		end else begin
			unp.special = 1'b0;
		end
	end

	// Stage registers: index 0 is unpack output, NSTG is last quotient bit
	div_state_t st_s1 [NSTG+1];
	logic       vld_s1 [NSTG+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1[0] <= 1'b0;
		else
			vld_s1[0] <= start;
	end

	always_ff @(posedge clk) begin
		st_s1[0] <= unp;
	end

	// One restoring-division step per stage
	for (genvar g = 0; g < NSTG; g++) begin : g_step
		div_state_t nxt;
		logic [25:0] diff;
		always_comb begin
			nxt  = st_s1[g];
			diff = {1'b0, st_s1[g].rem} - {2'b0, st_s1[g].dvsr};
			if (!diff[25]) begin
				nxt.rem = {diff[23:0], 1'b0};
				nxt.quo = {st_s1[g].quo[25:0], 1'b1};
			end else begin
				nxt.rem = {st_s1[g].rem[23:0], 1'b0};
				nxt.quo = {st_s1[g].quo[25:0], 1'b0};
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s1[g+1] <= 1'b0;
			else
				vld_s1[g+1] <= vld_s1[g];
		end
		always_ff @(posedge clk) begin
			st_s1[g+1] <= nxt;
		end
	end

	// Normalize, round and pack
	div_state_t  fin;
	logic [26:0] q;
	logic [9:0]  e;
	logic [24:0] sig;
	logic [2:0]  rnd;
	logic [31:0] res;

	always_comb begin
		fin = st_s1[NSTG];
		q = fin.quo;
		e = fin.exp;
		if (!q[26]) begin
			q = {q[25:0], 1'b0};
			e = e - 10'd1;
		end
		sig = {1'b0, q[26:3]};
		rnd = {q[2:1], q[0] | (fin.rem != '0)};
		if (rnd > 3'd4 || (rnd == 3'd4 && sig[0])) begin
			sig = sig + 25'd1;
			if (sig[24]) begin
				sig = sig >> 1;
				e = e + 10'd1;
			end
		end
		if (fin.special)
			res = fin.spec_val;
		else if (!e[9] && e >= 10'd255)
			res = {fin.sign, 31'b0} | INF_BITS;
		else if (e[9] || e == '0)
			res = {fin.sign, 31'b0};
		else
			res = {fin.sign, e[7:0], sig[22:0]};
	end

	// Output register
	logic        done_q;
	logic [31:0] quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= vld_s1[NSTG];
	end

	always_ff @(posedge clk) begin
		quo_q <= res;
	end

	assign busy          = 1'b0;
	assign done          = done_q;
	assign quotient_bits = quo_q;

endmodule
